### design/sync_word_frame_capture_defines.svh
// ----------------------------------------------------------------------------
// Sync word frame capture assertion macros
// Shared concurrent assertion forms, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_CAPTURE_DEFINES_SVH
`define SYNC_WORD_FRAME_CAPTURE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SWFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swfc assertion failed");
// Next-cycle implication.
`define SWFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swfc assertion failed");
`else
`define SWFC_ASSERT_NOW(label, clk, rst, ante, cons)
`define SWFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/swfc_pkg.sv
// ----------------------------------------------------------------------------
// Sync word frame capture package
// Types and fixed constants shared by the capture modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swfc_pkg;

   localparam int SYNC_MAX_BYTES = 8;
   localparam int DIM_LIMIT      = 256;

   localparam logic [3:0] CSR_SYNC_PATTERN = 4'd0;
   localparam logic [3:0] CSR_SYNC_LENGTH  = 4'd1;
   localparam logic [3:0] CSR_FRAME_WIDTH  = 4'd2;
   localparam logic [3:0] CSR_FRAME_HEIGHT = 4'd3;

   localparam logic [63:0] SYNC_PATTERN_RESET = 64'd6365912077073340504;
   localparam logic [3:0]  SYNC_LENGTH_RESET  = 4'd8;
   localparam logic [8:0]  FRAME_DIM_RESET    = 9'd96;

   localparam logic KIND_STRAY = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef enum logic {
      SWFC_HUNT,
      SWFC_CAPTURE
   } swfc_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] column;
      logic [7:0] row;
      logic       end_of_frame;
   } swfc_result_type;

   typedef struct packed {
      logic            valid;
      swfc_result_type result;
   } swfc_push_type;

endpackage

`default_nettype wire

### design/swfc_front.sv
// ----------------------------------------------------------------------------
// Sync word frame capture front end
// Holds the configuration, hunts for the sync pattern, passes stray bytes on and tags frame pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_word_frame_capture_defines.svh"

module swfc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [3:0]            csr_index,
   input  wire logic [63:0]           csr_data,
   input  wire logic                  queue_full,
   output swfc_pkg::swfc_push_type    push
);
   import swfc_pkg::*;

   logic [63:0]    sync_pattern_ff;
   logic [3:0]     sync_length_ff;
   logic [8:0]     frame_width_ff;
   logic [8:0]     frame_height_ff;

   swfc_state_type state_ff, state_in;
   logic [3:0]     match_count_ff, match_count_in;
   logic [7:0]     column_count_ff, column_count_in;
   logic [7:0]     row_count_ff, row_count_in;

   logic           accept;
   logic [7:0]     want;
   logic [3:0]     used_length;
   logic [3:0]     match_inc;
   logic           hit;
   logic           sync_done;
   logic [8:0]     width_eff;
   logic [8:0]     height_eff;
   logic [8:0]     column_inc;
   logic [8:0]     row_inc;
   logic           last_column;
   logic           last_row;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff <= SYNC_PATTERN_RESET;
         sync_length_ff  <= SYNC_LENGTH_RESET;
         frame_width_ff  <= FRAME_DIM_RESET;
         frame_height_ff <= FRAME_DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SYNC_PATTERN: sync_pattern_ff <= csr_data;
            CSR_SYNC_LENGTH:  sync_length_ff  <= csr_data[3:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[8:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      want      = sync_pattern_ff[{match_count_ff[2:0], 3'b000} +: 8];
      match_inc = match_count_ff + 4'd1;
      hit       = (req_rx_byte == want);
      if (sync_length_ff == 4'd0) begin
         used_length = 4'd1;
      end else if (sync_length_ff > 4'(SYNC_MAX_BYTES)) begin
         used_length = 4'(SYNC_MAX_BYTES);
      end else begin
         used_length = sync_length_ff;
      end
      sync_done = hit && (match_inc >= used_length);
      if (frame_width_ff == 9'd0) begin
         width_eff = 9'd1;
      end else if (frame_width_ff > 9'(DIM_LIMIT)) begin
         width_eff = 9'(DIM_LIMIT);
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff == 9'd0) begin
         height_eff = 9'd1;
      end else if (frame_height_ff > 9'(DIM_LIMIT)) begin
         height_eff = 9'(DIM_LIMIT);
      end else begin
         height_eff = frame_height_ff;
      end
      column_inc  = {1'b0, column_count_ff} + 9'd1;
      row_inc     = {1'b0, row_count_ff} + 9'd1;
      last_column = (column_inc >= width_eff);
      last_row    = (row_inc >= height_eff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SWFC_HUNT: begin
            if (accept && sync_done) begin
               state_in = SWFC_CAPTURE;
            end
         end
         SWFC_CAPTURE: begin
            if (accept && last_column && last_row) begin
               state_in = SWFC_HUNT;
            end
         end
         default: state_in = SWFC_HUNT;
      endcase
   end

   always_comb begin
      match_count_in           = match_count_ff;
      column_count_in          = column_count_ff;
      row_count_in             = row_count_ff;
      push.valid               = 1'b0;
      push.result.kind         = KIND_STRAY;
      push.result.data_byte    = req_rx_byte;
      push.result.column       = 8'd0;
      push.result.row          = 8'd0;
      push.result.end_of_frame = 1'b0;
      case (state_ff)
         SWFC_HUNT: begin
            if (accept) begin
               if (hit) begin
                  match_count_in  = sync_done ? 4'd0 : match_inc;
                  column_count_in = 8'd0;
                  row_count_in    = 8'd0;
               end else begin
                  match_count_in = 4'd0;
                  push.valid     = 1'b1;
               end
            end
         end
         SWFC_CAPTURE: begin
            push.result.kind         = KIND_PIXEL;
            push.result.column       = column_count_ff;
            push.result.row          = row_count_ff;
            push.result.end_of_frame = last_column && last_row;
            if (accept) begin
               push.valid = 1'b1;
               if (!last_column) begin
                  column_count_in = column_inc[7:0];
               end else begin
                  column_count_in = 8'd0;
                  if (!last_row) begin
                     row_count_in = row_inc[7:0];
                  end else begin
                     row_count_in   = 8'd0;
                     match_count_in = 4'd0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SWFC_HUNT;
         match_count_ff  <= 4'd0;
         column_count_ff <= 8'd0;
         row_count_ff    <= 8'd0;
      end else begin
         state_ff        <= state_in;
         match_count_ff  <= match_count_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   `SWFC_ASSERT_NOW(a_capture_no_match, clock, reset, state_ff == SWFC_CAPTURE, match_count_ff == 4'd0)
   `SWFC_ASSERT_NOW(a_hunt_counters_clear, clock, reset, state_ff == SWFC_HUNT, (column_count_ff == 8'd0) && (row_count_ff == 8'd0))
   `SWFC_ASSERT_NOW(a_push_needs_transfer, clock, reset, push.valid, req_valid && !queue_full)

endmodule

`default_nettype wire

### design/swfc_queue.sv
// ----------------------------------------------------------------------------
// Sync word frame capture result queue
// Small first-in first-out buffer between the front end and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_word_frame_capture_defines.svh"

module swfc_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire swfc_pkg::swfc_push_type   push,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           not_empty,
   output swfc_pkg::swfc_result_type      head
);
   import swfc_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   swfc_result_type       entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push.valid;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SWFC_ASSERT_NOW(a_no_push_when_full, clock, reset, push.valid, !full)
   `SWFC_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= COUNT_BITS'(DEPTH))

endmodule

`default_nettype wire

### design/swfc_back.sv
// ----------------------------------------------------------------------------
// Sync word frame capture output stage
// Drains the result queue into a registered response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swfc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      not_empty,
   input  wire swfc_pkg::swfc_result_type head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_kind,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_column,
   output logic [7:0]                     rsp_row,
   output logic                           rsp_end_of_frame
);
   import swfc_pkg::*;

   logic            valid_ff, valid_in;
   swfc_result_type result_ff;

   assign pop = not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= head;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = result_ff.kind;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_column       = result_ff.column;
   assign rsp_row          = result_ff.row;
   assign rsp_end_of_frame = result_ff.end_of_frame;

endmodule

`default_nettype wire

### design/sync_word_frame_capture.sv
// ----------------------------------------------------------------------------
// Sync word frame capture
// Each result is queued, then registered in the output stage, and offered on rsp_valid.
// Throughput: one byte per cycle; req_stall rises only when the result queue is full.
// A matched sync byte gives no result; every other byte gives exactly one.
// Reset clears the hunt state, counters and queue, and loads the default registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_capture #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_column,
   output logic [7:0]       rsp_row,
   output logic             rsp_end_of_frame,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import swfc_pkg::*;

   swfc_push_type   push;
   swfc_result_type head;
   logic            queue_full;
   logic            queue_not_empty;
   logic            pop;

   swfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   swfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   swfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (queue_not_empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

### tb/sync_word_frame_capture_tb.sv
// ----------------------------------------------------------------------------
// Sync word frame capture testbench
// Drives received bytes into the deframer through a queue-fed driver, tracks
// the expected stray bytes and frame pixels with an independent model of the
// hunt and capture logic, and checks every result transfer field by field.
// Register settings change between phases while the block is idle; bytes
// arrive with random gaps, and the result channel stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_word_frame_capture_tb;

   import swfc_pkg::*;

   localparam int          CLOCK_PERIOD  = 12;
   localparam int          RESET_CYCLES  = 8;
   localparam int          RANDOM_ITEMS  = 600;
   localparam int          LONG_HOLD     = 300;
   localparam int          QUIET_LIMIT   = 4000;
   localparam int          SETTLE_CYCLES = 4;
   localparam logic [3:0]  CSR_INDEX_TOP = 4'hF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_column;
   logic [7:0]  rsp_row;
   logic        rsp_end_of_frame;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = 4'h0;
   logic [63:0] csr_data = 64'h0;

   // Bytes waiting to be offered, and results expected from the block.
   logic [7:0]      tx_bytes[$];
   swfc_result_type predicted_results[$];

   // Tracked copy of the deframer registers and state.
   logic [63:0] trk_pattern;
   logic [3:0]  trk_length;
   logic [8:0]  trk_width;
   logic [8:0]  trk_height;
   logic        trk_capturing;
   logic [3:0]  trk_match;
   int          trk_column;
   int          trk_row;

   // Register values as last written, used to build byte sequences.
   logic [63:0] gen_pattern = SYNC_PATTERN_RESET;
   logic [3:0]  gen_length  = SYNC_LENGTH_RESET;
   logic [8:0]  gen_width   = FRAME_DIM_RESET;
   logic [8:0]  gen_height  = FRAME_DIM_RESET;

   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_serial = 0;
   int hold_seen = 0;
   bit send_smooth = 1'b0;
   bit recv_smooth = 1'b0;
   int quiet_cycles = 0;
   int error_count = 0;
   int items_queued = 0;
   int bytes_in = 0;
   int results_out = 0;
   int frames_closed = 0;
   int csr_writes = 0;

   sync_word_frame_capture uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int sync_span(input logic [3:0] length);
      if (length == 4'd0) return 1;
      if (length > SYNC_MAX_BYTES) return SYNC_MAX_BYTES;
      return length;
   endfunction

   function automatic int frame_dim(input logic [8:0] dim);
      if (dim == 9'd0) return 1;
      if (dim > DIM_LIMIT) return DIM_LIMIT;
      return dim;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [8:0] small_dim();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 9'd0;
      if (roll == 1) return 9'($urandom_range(7, 16));
      return 9'($urandom_range(1, 6));
   endfunction

   function automatic logic [7:0] sync_byte(input int position);
      return gen_pattern[8 * position +: 8];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic advance_deframer(input logic [7:0] rx);
      swfc_result_type out;
      int              width_used;
      int              height_used;
      logic            last_col;
      logic            last_row;
      if (!trk_capturing) begin
         if (rx == trk_pattern[8 * trk_match[2:0] +: 8]) begin
            trk_match = trk_match + 4'd1;
            if (trk_match >= sync_span(trk_length)) begin
               trk_capturing = 1'b1;
               trk_match = 4'd0;
               trk_column = 0;
               trk_row = 0;
            end
         end else begin
            trk_match = 4'd0;
            out.kind = KIND_STRAY;
            out.data_byte = rx;
            out.column = 8'd0;
            out.row = 8'd0;
            out.end_of_frame = 1'b0;
            predicted_results.push_back(out);
         end
      end else begin
         width_used = frame_dim(trk_width);
         height_used = frame_dim(trk_height);
         last_col = (trk_column + 1) >= width_used;
         last_row = (trk_row + 1) >= height_used;
         out.kind = KIND_PIXEL;
         out.data_byte = rx;
         out.column = trk_column[7:0];
         out.row = trk_row[7:0];
         out.end_of_frame = last_col && last_row;
         predicted_results.push_back(out);
         if (!last_col) begin
            trk_column = (trk_column + 1) & 8'hFF;
         end else begin
            trk_column = 0;
            if (!last_row) begin
               trk_row = (trk_row + 1) & 8'hFF;
            end else begin
               trk_row = 0;
               trk_capturing = 1'b0;
               trk_match = 4'd0;
            end
         end
      end
   endtask

   // Byte driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (tx_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_rx_byte <= tx_bytes.pop_front();
            send_gap <= send_smooth ? 0 : pick_gap();
         end
      end
   end

   // Result monitor: tracks register writes and byte transfers, checks result
   // transfers, and drives the result stall.
   always @(posedge clock) begin : result_check
      swfc_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         trk_pattern = SYNC_PATTERN_RESET;
         trk_length = SYNC_LENGTH_RESET;
         trk_width = FRAME_DIM_RESET;
         trk_height = FRAME_DIM_RESET;
         trk_capturing = 1'b0;
         trk_match = 4'd0;
         trk_column = 0;
         trk_row = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_SYNC_PATTERN: trk_pattern = csr_data;
               CSR_SYNC_LENGTH:  trk_length = csr_data[3:0];
               CSR_FRAME_WIDTH:  trk_width = csr_data[8:0];
               CSR_FRAME_HEIGHT: trk_height = csr_data[8:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            bytes_in++;
            advance_deframer(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            results_out++;
            if (rsp_end_of_frame === 1'b1) frames_closed++;
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, byte %02h",
                                         rsp_data_byte));
            end else begin
               want = predicted_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
               if (rsp_data_byte !== want.data_byte)
                  report_mismatch($sformatf("data_byte got %02h want %02h",
                                            rsp_data_byte, want.data_byte));
               if (rsp_column !== want.column)
                  report_mismatch($sformatf("column got %0d want %0d",
                                            rsp_column, want.column));
               if (rsp_row !== want.row)
                  report_mismatch($sformatf("row got %0d want %0d", rsp_row, want.row));
               if (rsp_end_of_frame !== want.end_of_frame)
                  report_mismatch($sformatf("end_of_frame got %0d want %0d",
                                            rsp_end_of_frame, want.end_of_frame));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_serial != hold_seen) begin
            rsp_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_seen <= hold_serial;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!recv_smooth && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [3:0] index, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_SYNC_PATTERN: gen_pattern = value;
         CSR_SYNC_LENGTH:  gen_length = value[3:0];
         CSR_FRAME_WIDTH:  gen_width = value[8:0];
         CSR_FRAME_HEIGHT: gen_height = value[8:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Waits until every byte is sent and every result has arrived, then lets
   // sync bytes that give no result clear the pipeline.
   task automatic settle();
      @(negedge clock);
      while (tx_bytes.size() != 0 || req_valid || predicted_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] value);
      tx_bytes.push_back(value);
      items_queued++;
   endtask

   task automatic queue_sync(input int count);
      for (int i = 0; i < count; i++) queue_byte(sync_byte(i));
   endtask

   task automatic queue_pixels(input int count);
      for (int i = 0; i < count; i++) queue_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int          phase;
      int          random_goal;
      int          sequences;
      int          roll;
      int          span;
      int          total;
      int          prefix;
      logic [63:0] value;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default registers: byte extremes and a broken default sync word.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_sync(2);
      queue_byte(~sync_byte(2));
      settle();

      // Zero length and zero dimensions act as one; an unknown index is ignored.
      write_reg(CSR_SYNC_PATTERN, 64'h0);
      write_reg(CSR_SYNC_LENGTH, 64'h0);
      write_reg(CSR_FRAME_WIDTH, 64'h0);
      write_reg(CSR_FRAME_HEIGHT, 64'h0);
      write_reg(CSR_INDEX_TOP, '1);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h01);
      settle();

      write_reg(CSR_SYNC_PATTERN, '1);
      write_reg(CSR_SYNC_LENGTH, 64'd2);
      write_reg(CSR_FRAME_WIDTH, 64'd2);
      write_reg(CSR_FRAME_HEIGHT, 64'd2);
      queue_sync(2);
      queue_byte(8'h00);
      queue_byte(8'h80);
      queue_byte(8'h7F);
      queue_byte(8'hFF);
      settle();

      // The length is cut below a partial match count.
      write_reg(CSR_SYNC_PATTERN, rand_word());
      write_reg(CSR_SYNC_LENGTH, 64'd8);
      queue_sync(5);
      settle();
      write_reg(CSR_SYNC_LENGTH, 64'd3);
      write_reg(CSR_FRAME_WIDTH, 64'd1);
      write_reg(CSR_FRAME_HEIGHT, 64'd1);
      queue_byte(sync_byte(5));
      queue_pixels(1);
      settle();

      // The frame shrinks while capture is under way.
      write_reg(CSR_SYNC_LENGTH, 64'd1);
      write_reg(CSR_FRAME_WIDTH, 64'd8);
      write_reg(CSR_FRAME_HEIGHT, 64'd8);
      queue_sync(1);
      queue_pixels(4);
      settle();
      write_reg(CSR_FRAME_WIDTH, 64'd2);
      write_reg(CSR_FRAME_HEIGHT, 64'd1);
      queue_pixels(1);
      settle();

      // Random phases. Phases 1 and 4 carry one frame at the size limit.
      phase = 0;
      random_goal = RANDOM_ITEMS;
      while (items_queued < random_goal || phase < 5) begin
         send_smooth = ($urandom_range(0, 3) == 0);
         recv_smooth = ($urandom_range(0, 3) == 0);
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) value = 64'h0;
            else if (roll == 1) value = '1;
            else if (roll == 2) value = {8{8'($urandom_range(0, 255))}};
            else value = rand_word();
            write_reg(CSR_SYNC_PATTERN, value);
         end
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            value = rand_word();
            value[3:0] = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4))
                                                    : 4'($urandom_range(0, 15));
            write_reg(CSR_SYNC_LENGTH, value);
         end
         if (phase == 1 || phase == 4 || phase == 0 || $urandom_range(0, 2) == 0) begin
            value = rand_word();
            value[8:0] = (phase == 1) ? 9'($urandom_range(DIM_LIMIT + 1, 511)) :
                         (phase == 4) ? 9'd1 : small_dim();
            write_reg(CSR_FRAME_WIDTH, value);
         end
         if (phase == 1 || phase == 4 || phase == 0 || $urandom_range(0, 2) == 0) begin
            value = rand_word();
            value[8:0] = (phase == 4) ? 9'($urandom_range(DIM_LIMIT, 511)) :
                         (phase == 1) ? 9'd1 : small_dim();
            write_reg(CSR_FRAME_HEIGHT, value);
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(4'($urandom_range(CSR_FRAME_HEIGHT + 1, CSR_INDEX_TOP)), rand_word());

         span = sync_span(gen_length);
         total = frame_dim(gen_width) * frame_dim(gen_height);
         if (phase == 1 || phase == 4) begin
            queue_sync(span);
            queue_pixels(total);
         end else begin
            if (phase == 2) begin
               // The receiver holds off while the sender keeps offering bytes.
               send_smooth = 1'b1;
               hold_serial++;
               queue_pixels(24);
            end
            sequences = $urandom_range(1, 6);
            for (int s = 0; s < sequences; s++) begin
               roll = $urandom_range(0, 99);
               if (roll < 60) begin
                  queue_sync(span);
                  queue_pixels(total);
               end else if (roll < 75) begin
                  prefix = $urandom_range(0, span - 1);
                  queue_sync(prefix);
                  queue_byte(sync_byte(prefix) ^ (8'h01 << $urandom_range(0, 7)));
               end else if (roll < 90 || phase == 0 || phase == 3 || total < 2) begin
                  queue_pixels($urandom_range(1, 4));
               end else begin
                  // Leave the frame open so the next settings apply mid-frame.
                  queue_sync(span);
                  queue_pixels($urandom_range(1, total - 1));
                  s = sequences;
               end
            end
         end
         settle();
         phase++;
      end

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (predicted_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
      $display("Sent %0d bytes over %0d phases with %0d register writes.",
               bytes_in, phase, csr_writes);
      $display("Checked %0d results including %0d completed frames.",
               results_out, frames_closed);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
